### hdl/fiir_pkg.sv
// Shared constants and types of the fourth-order IIR filter block.
package fiir_pkg;

	localparam int AXES      = 3;
	localparam int TAPS      = 4;
	localparam int SLOT_W    = 2;
	localparam int AXIS_W    = $clog2(AXES);
	localparam int COEF_W    = 32;
	localparam int NCOEF     = 2 * TAPS + 1;
	localparam int FRAC_BITS = 28;

	localparam int CFG_DATA_W = 2 * COEF_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_FF01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FF23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FF4  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FB12 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FB34 = 3'd4;

	// Per-axis step: newest input, four past inputs, four past outputs.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_X0   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_Y1   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;
	localparam logic [STEP_W-1:0] STEP_XWR  = STEP_Y1;

	// History memory: {axis, bank, slot}.
	localparam logic SEL_X = 1'b0;
	localparam logic SEL_Y = 1'b1;
	localparam int MEM_DEPTH = AXES * 2 * TAPS;
	localparam int MEM_AW    = AXIS_W + 1 + SLOT_W;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic              neg;
		logic [AXIS_W-1:0] axis;
	} mac_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [AXIS_W-1:0] axis;
	} res_tag_t;

endpackage

### hdl/fiir_if.sv
// Stream interfaces for the sample input and the filtered output.
interface fiir_in_if #(parameter int SW = 24) ();
	logic          valid;
	logic          ready;
	logic [SW-1:0] sample_x;
	logic [SW-1:0] sample_y;
	logic [SW-1:0] sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface fiir_out_if #(parameter int SW = 24) ();
	logic          valid;
	logic          ready;
	logic [SW-1:0] filt_x;
	logic [SW-1:0] filt_y;
	logic [SW-1:0] filt_z;

	modport source (output valid, output filt_x, output filt_y, output filt_z,
		input ready);
	modport sink (input valid, input filt_x, input filt_y, input filt_z,
		output ready);
endinterface

### hdl/fiir_coef.sv
// Coefficient registers, unpacked into nine signed Q4.28 weights.
module fiir_coef (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fiir_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fiir_pkg::CFG_DATA_W-1:0] cfg_data,
	output fiir_pkg::coef_t                 coef [fiir_pkg::NCOEF]
);
	import fiir_pkg::*;

	coef_t coef_q [NCOEF];
	coef_t lo_half;
	coef_t hi_half;

	assign lo_half = $signed(cfg_data[COEF_W-1:0]);
	assign hi_half = $signed(cfg_data[2*COEF_W-1:COEF_W]);

	// Order: b0..b4, then a1..a4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FF01: begin
					coef_q[0] <= lo_half;
					coef_q[1] <= hi_half;
				end
				CFG_FF23: begin
					coef_q[2] <= lo_half;
					coef_q[3] <= hi_half;
				end
				CFG_FF4: begin
					coef_q[4] <= lo_half;
				end
				CFG_FB12: begin
					coef_q[5] <= lo_half;
					coef_q[6] <= hi_half;
				end
				CFG_FB34: begin
					coef_q[7] <= lo_half;
					coef_q[8] <= hi_half;
				end
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

### hdl/fiir_mem.sv
// History memory for past inputs and outputs, one read and one write port.
module fiir_mem #(
	parameter int SW = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fiir_pkg::MEM_AW-1:0] rd_addr,
	output logic signed [SW-1:0]        rd_data,
	input  logic                        wr_en,
	input  logic [fiir_pkg::MEM_AW-1:0] wr_addr,
	input  logic signed [SW-1:0]        wr_data
);
	import fiir_pkg::*;

	logic signed [SW-1:0] mem_q [MEM_DEPTH];
	logic signed [SW-1:0] rd_q;
	logic [MEM_DEPTH-1:0] vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### hdl/fiir_mac.sv
// Shared multiply-accumulate unit with rounding and saturation.
module fiir_mac #(
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fiir_pkg::mac_ctl_t   ctl_s1,
	input  logic signed [SW-1:0] opnd_s1,
	input  fiir_pkg::coef_t      coef_s1,
	output fiir_pkg::res_tag_t   res_tag,
	output logic signed [SW-1:0] res_y
);
	import fiir_pkg::*;

	localparam int PROD_W = SW + COEF_W;
	localparam int ACC_W  = PROD_W + 4;
	localparam int QW     = ACC_W + 1 - FRAC_BITS;
	localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

	mac_ctl_t                ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	res_tag_t                tag_s3;

	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W:0]   rnd;
	logic [QW-1:0]           quo;
	logic                    ovf_pos;
	logic                    ovf_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			ctl_s2       <= ctl_s1;
			tag_s3.valid <= ctl_s2.valid && ctl_s2.last;
			tag_s3.axis  <= ctl_s2.axis;
		end
	end

	assign prod_ext = ACC_W'(prod_s2);
	assign acc_base = ctl_s2.first ? '0 : acc_s3;

	always_ff @(posedge clk) begin
		prod_s2 <= opnd_s1 * coef_s1;
		if (ctl_s2.valid) acc_s3 <= ctl_s2.neg ? acc_base - prod_ext : acc_base + prod_ext;
	end

	// Round half up, then clamp to the sample range.
	assign rnd     = (ACC_W + 1)'(acc_s3) + RND_HALF;
	assign quo     = rnd[ACC_W:FRAC_BITS];
	assign ovf_pos = !quo[QW-1] && (|quo[QW-2:SW-1]);
	assign ovf_neg = quo[QW-1] && !(&quo[QW-2:SW-1]);

	always_comb begin
		if (ovf_pos)      res_y = {1'b0, {(SW - 1){1'b1}}};
		else if (ovf_neg) res_y = {1'b1, {(SW - 1){1'b0}}};
		else              res_y = $signed(quo[SW-1:0]);
	end

	assign res_tag = tag_s3;

endmodule

### hdl/fourth_order_iir_vec3.sv
// Fourth-order IIR filter over three axes; history in memory, one shared MAC.
// Pacing: a new item starts only after the last history write of the current one; one more
//   input beat is buffered meanwhile. The pace is set by nine multiply-accumulates per axis
//   on the single multiplier plus the drain of the three-stage MAC pipeline.
// Reset: arst_n clears coefficients, valid bits of the history memory (history reads
//   as zero) and all handshake state; no clearing sweep is needed.
module fourth_order_iir_vec3 #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fiir_in_if.sink                         in_ch,
	fiir_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [fiir_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fiir_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fiir_pkg::*;

	localparam int SW = SAMPLE_WIDTH;

	coef_t coef [NCOEF];

	logic                 in_v_q;
	logic signed [SW-1:0] in_q [AXES];
	logic signed [SW-1:0] x_q [AXES];

	logic                 busy_q;
	logic                 item_q;
	logic [AXIS_W-1:0]    axis_q;
	logic [STEP_W-1:0]    step_q;
	logic [SLOT_W-1:0]    wp_q;

	mac_ctl_t             ctl_s1;
	logic [STEP_W-1:0]    step_s1;

	logic                 res_v_q;
	logic signed [SW-1:0] res_q [AXES];
	logic                 out_v_q;
	logic signed [SW-1:0] out_q [AXES];

	logic                 accept;
	logic                 res_move;
	logic                 start;
	logic                 done;
	logic                 last_axis;
	logic [STEP_W-1:0]    step_m1;
	logic [SLOT_W-1:0]    rd_slot;
	logic                 rd_sel;
	logic [MEM_AW-1:0]    rd_addr;
	logic signed [SW-1:0] rd_data;
	logic                 x_wr;
	logic                 wr_en;
	logic [MEM_AW-1:0]    wr_addr;
	logic signed [SW-1:0] wr_data;
	logic signed [SW-1:0] opnd_s1;
	coef_t                coef_s1;
	res_tag_t             res_tag;
	logic signed [SW-1:0] res_y;

	fiir_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coef     (coef)
	);

	fiir_mem #(.SW(SW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	fiir_mac #(.SW(SW)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.opnd_s1 (opnd_s1),
		.coef_s1 (coef_s1),
		.res_tag (res_tag),
		.res_y   (res_y)
	);

	assign in_ch.ready = !in_v_q;
	assign accept      = in_ch.valid && in_ch.ready;
	assign res_move    = res_v_q && (!out_v_q || out_ch.ready);
	// Next item starts only after the last history write of the current one.
	assign start       = !item_q && in_v_q && (!res_v_q || res_move);
	assign last_axis   = (axis_q == AXIS_W'(AXES - 1));
	assign done        = res_tag.valid && (res_tag.axis == AXIS_W'(AXES - 1));

	// Past sample k sits at slot wp - k; inputs and outputs share the slot math.
	assign step_m1 = step_q - STEP_W'(1);
	assign rd_slot = wp_q - SLOT_W'(1) - step_m1[SLOT_W-1:0];
	assign rd_sel  = (step_q >= STEP_Y1) ? SEL_Y : SEL_X;
	assign rd_addr = {axis_q, rd_sel, rd_slot};

	// The newest input overwrites the oldest only after that one was read.
	assign x_wr    = busy_q && (step_q == STEP_XWR);
	assign wr_en   = x_wr || res_tag.valid;
	assign wr_addr = res_tag.valid ? {res_tag.axis, SEL_Y, wp_q} : {axis_q, SEL_X, wp_q};
	assign wr_data = res_tag.valid ? res_y : x_q[axis_q];

	assign opnd_s1 = ctl_s1.first ? x_q[ctl_s1.axis] : rd_data;
	assign coef_s1 = coef[step_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q  <= 1'b0;
			busy_q  <= 1'b0;
			item_q  <= 1'b0;
			axis_q  <= '0;
			step_q  <= STEP_X0;
			wp_q    <= '0;
			ctl_s1  <= '0;
			step_s1 <= STEP_X0;
			res_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept)     in_v_q <= 1'b1;
			else if (start) in_v_q <= 1'b0;

			if (start) begin
				busy_q <= 1'b1;
				item_q <= 1'b1;
				axis_q <= '0;
				step_q <= STEP_X0;
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					step_q <= STEP_X0;
					if (last_axis) busy_q <= 1'b0;
					else           axis_q <= axis_q + AXIS_W'(1);
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end

			if (done) begin
				item_q <= 1'b0;
				wp_q   <= wp_q + SLOT_W'(1);
			end

			ctl_s1.valid <= busy_q;
			ctl_s1.first <= (step_q == STEP_X0);
			ctl_s1.last  <= (step_q == STEP_LAST);
			ctl_s1.neg   <= (step_q >= STEP_Y1);
			ctl_s1.axis  <= axis_q;
			step_s1      <= step_q;

			if (done)          res_v_q <= 1'b1;
			else if (res_move) res_v_q <= 1'b0;

			if (res_move)          out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q[0] <= in_ch.sample_x;
			in_q[1] <= in_ch.sample_y;
			in_q[2] <= in_ch.sample_z;
		end
		if (start) x_q <= in_q;
		if (res_tag.valid) res_q[res_tag.axis] <= res_y;
		if (res_move) out_q <= res_q;
	end

	assign out_ch.valid  = out_v_q;
	assign out_ch.filt_x = out_q[0];
	assign out_ch.filt_y = out_q[1];
	assign out_ch.filt_z = out_q[2];

endmodule

### hdl/fiir_checker.sv
// Port-level checks of the filter block, bound to the top level.
module fiir_checker #(
	parameter int SW = 24
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [SW-1:0] filt_x,
	input logic [SW-1:0] filt_y,
	input logic [SW-1:0] filt_z
);
	logic [2:0] cnt_q;

	// Items taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output beat offered during reset");

	a_in_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input buffer took a beat without filling");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 3'd0)
		else $error("output beat with no item outstanding");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(filt_x) && $stable(filt_y) && $stable(filt_z))
		else $error("output payload changed while stalled");

endmodule

bind fourth_order_iir_vec3 fiir_checker #(.SW(SAMPLE_WIDTH)) u_fiir_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.filt_x    (out_ch.filt_x),
	.filt_y    (out_ch.filt_y),
	.filt_z    (out_ch.filt_z)
);
